>>> rtl/bfa_pkg.sv
// Shared types, constants and helpers for the fixed-point to ASCII formatter.
// No dependencies; every other file in rtl/ uses this package.
`timescale 1ns / 1ps
package bfa_pkg;

    // Payload widths
    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 7;
    localparam int H_W        = 17;   // hundredths, at most 99999
    localparam int DIG_W      = 4;
    localparam int NUM_DIGITS = 5;
    localparam int NUM_CELLS  = 4;    // digits split off by the chain; the fifth digit is the remainder
    localparam int NUM_CHARS  = 6;
    localparam int PLACE_W    = 2;
    localparam int IDX_W      = 3;

    // Scaling: hundredths = (value * SCALE) >> FRAC_BITS
    localparam int MUL_IN_W   = 18;
    localparam int SCALE_W    = 7;
    localparam int PROD_W     = MUL_IN_W + SCALE_W;
    localparam int FRAC_BITS  = 8;
    localparam logic [SCALE_W-1:0] SCALE       = 7'd100;
    localparam logic [VALUE_W-1:0] LIMIT_VALUE = 32'd256000;

    // Character codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] ASCII_DOT   = 7'h2e;
    localparam logic [CHAR_W-1:0] ASCII_STAR  = 7'h2a;

    // Word handed from cell to cell
    typedef struct packed {
        logic                               ovf;
        logic [H_W-1:0]                     rem;
        logic [NUM_DIGITS-1:0][DIG_W-1:0]   digit;
    } fmt_t;

    // Weight of the digit a cell splits off, by its place in the chain
    function automatic logic [H_W-1:0] place_weight(input logic [PLACE_W-1:0] place);
        logic [H_W-1:0] w;
        case (place)
            2'd0:    w = 17'd10000;
            2'd1:    w = 17'd1000;
            2'd2:    w = 17'd100;
            2'd3:    w = 17'd10;
            default: w = 17'd10;
        endcase
        return w;
    endfunction

    // ASCII code of a decimal digit
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
        return ASCII_ZERO + CHAR_W'(d);
    endfunction

endpackage

>>> rtl/bfa_ifs.sv
// Stream interfaces for the formatter: fixed-point samples in, characters out.
// Depends on bfa_pkg.
`timescale 1ns / 1ps
interface bfa_in_if;
    logic                        valid;
    logic                        ready;
    logic [bfa_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface bfa_out_if;
    logic                       valid;
    logic                       ready;
    logic [bfa_pkg::CHAR_W-1:0] char_code;
    logic                       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

>>> rtl/binary_fixed_to_ascii_top.sv
// Top level of the fixed-point to decimal ASCII formatter.
// Depends on bfa_pkg, bfa_ifs, bfa_front, bfa_digit_cell and bfa_serializer.
`timescale 1ns / 1ps
// Each sample on the input stream (unsigned, 1/256 units) becomes six ASCII
// beats on the text stream, e.g. "  0.00", " 12.34" or "***.**" when the
// sample is 256000 or more; last marks the sixth beat. The sample passes a
// scaling stage and a chain of four digit cells, each registered, and is then
// loaded into the serializer's character register, from which the first
// character is offered. The serializer sends one character per cycle while the
// text stream is ready; the front stage and cells keep accepting samples while
// earlier text is still going out, until their registers are full, and no reset
// pass or warm-up is needed.
module binary_fixed_to_ascii_top (
    input  logic       clk,
    input  logic       rst_n,
    bfa_in_if.sink     sample,
    bfa_out_if.source  text
);
    import bfa_pkg::*;

    logic [NUM_CELLS:0] stage_valid;
    logic [NUM_CELLS:0] stage_ready;
    fmt_t               stage_data [NUM_CELLS+1];

    // Range check and scaling
    bfa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_data  (stage_data[0])
    );

    // Digit chain, most significant place first
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        bfa_digit_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .place     (PLACE_W'(k)),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_data   (stage_data[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_data  (stage_data[k+1])
        );
    end

    // Text assembly and character output
    bfa_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stage_valid[NUM_CELLS]),
        .in_ready (stage_ready[NUM_CELLS]),
        .in_data  (stage_data[NUM_CELLS]),
        .text     (text)
    );
endmodule

>>> rtl/bfa_front.sv
// Front stage: range check and scaling of the sample to hundredths.
// Depends on bfa_pkg and bfa_ifs.
`timescale 1ns / 1ps
module bfa_front (
    input  logic               clk,
    input  logic               rst_n,
    bfa_in_if.sink             sample,
    output logic               out_valid,
    input  logic               out_ready,
    output bfa_pkg::fmt_t      out_data
);
    import bfa_pkg::*;

    logic                valid_reg;
    fmt_t                data_reg;
    fmt_t                data_next;
    logic [PROD_W-1:0]   prod;
    logic                ovf;

    assign sample.ready = !valid_reg || out_ready;

    // Scale: in range the value fits in 18 bits, so an 18x7 product suffices
    always_comb
    begin
        ovf             = (sample.value >= LIMIT_VALUE);
        prod            = PROD_W'(sample.value[MUL_IN_W-1:0]) * PROD_W'(SCALE);
        data_next       = '0;
        data_next.ovf   = ovf;
        data_next.rem   = ovf ? '0 : prod[FRAC_BITS +: H_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (sample.ready)
            valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

>>> rtl/bfa_digit_cell.sv
// One cell of the digit chain: splits the leading decimal digit off the remainder.
// Depends on bfa_pkg.
`timescale 1ns / 1ps
module bfa_digit_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bfa_pkg::PLACE_W-1:0]   place,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bfa_pkg::fmt_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bfa_pkg::fmt_t                 out_data
);
    import bfa_pkg::*;

    logic            valid_reg;
    fmt_t            data_reg;
    fmt_t            data_next;
    logic [H_W-1:0]  weight;
    logic [DIG_W-1:0] dig;
    logic [H_W-1:0]  sub;

    assign in_ready = !valid_reg || out_ready;
    assign weight   = place_weight(place);

    // Digit: highest multiple of the weight not above the remainder (rem < 10*weight)
    always_comb
    begin
        dig = '0;
        sub = '0;
        for (int m = 1; m < 10; m++)
        begin
            if (in_data.rem >= H_W'(m) * weight)
            begin
                dig = DIG_W'(m);
                sub = H_W'(m) * weight;
            end
        end
        data_next              = in_data;
        data_next.rem          = in_data.rem - sub;
        data_next.digit[place] = dig;
        if (place == PLACE_W'(NUM_CELLS - 1))
            data_next.digit[NUM_DIGITS-1] = DIG_W'(in_data.rem - sub);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule

>>> rtl/bfa_serializer.sv
// Builds the six-character text from the digits; shifts out a beat per ready cycle.
// Depends on bfa_pkg and bfa_ifs.
`timescale 1ns / 1ps
module bfa_serializer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bfa_pkg::fmt_t      in_data,
    bfa_out_if.source          text
);
    import bfa_pkg::*;

    logic                                 busy_reg;
    logic [IDX_W-1:0]                     idx_reg;
    logic [NUM_CHARS-1:0][CHAR_W-1:0]     chars_reg;
    logic [NUM_CHARS-1:0][CHAR_W-1:0]     chars_next;
    logic                                 lead;
    logic                                 is_last;
    logic                                 beat;
    logic                                 load;

    assign is_last  = (idx_reg == IDX_W'(NUM_CHARS - 1));
    assign beat     = busy_reg && text.ready;
    assign in_ready = !busy_reg || (text.ready && is_last);
    assign load     = in_valid && in_ready;

    // Text layout with leading blanks; overflow shows stars
    always_comb
    begin
        lead = (in_data.digit[0] != '0);
        if (in_data.ovf)
        begin
            chars_next[0] = ASCII_STAR;
            chars_next[1] = ASCII_STAR;
            chars_next[2] = ASCII_STAR;
            chars_next[3] = ASCII_DOT;
            chars_next[4] = ASCII_STAR;
            chars_next[5] = ASCII_STAR;
        end
        else
        begin
            chars_next[0] = lead ? digit_char(in_data.digit[0]) : ASCII_SPACE;
            chars_next[1] = (lead || in_data.digit[1] != '0) ?
                            digit_char(in_data.digit[1]) : ASCII_SPACE;
            chars_next[2] = digit_char(in_data.digit[2]);
            chars_next[3] = ASCII_DOT;
            chars_next[4] = digit_char(in_data.digit[3]);
            chars_next[5] = digit_char(in_data.digit[4]);
        end
    end

    // Control: busy flag and character index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (beat)
        begin
            if (is_last)
                busy_reg <= 1'b0;
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // Character shift register, head at index 0
    always_ff @(posedge clk)
    begin
        if (load)
            chars_reg <= chars_next;
        else if (beat)
        begin
            for (int i = 0; i < NUM_CHARS - 1; i++)
                chars_reg[i] <= chars_reg[i+1];
        end
    end

    assign text.valid     = busy_reg;
    assign text.char_code = chars_reg[0];
    assign text.last      = is_last;
endmodule
